[design/hjct_pkg.sv]
// Package for the hash-join chained table engine.
// Holds item kinds, status codes and default sizes; no dependencies.
package hjct_pkg;

    localparam int MAX_ENTRIES_DEF  = 1024;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int HASH_BITS        = 64;
    localparam int COUNT_BITS       = 11;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_BUILD  = 2'd1,
        KIND_PROBE  = 2'd2,
        KIND_NEXT   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_PHASE = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

endpackage

[design/hash_join_chained_table.sv]
// Hash-join chained table: insert, build, probe and next over one entry store; uses hjct_pkg.
// Result path: insert, phase error and next at chain end answer straight from idle; probe
// and next read head or link, then entry; build: clear sweep, then read/read/write per entry.
// Throughput: one word at a time; input is held off while a result waits.
// Reset (rst_n, async low) empties the store, clears built state and cursor; memory contents
// are not reset, build clears the heads it uses.
module hash_join_chained_table #(
    parameter int MAX_ENTRIES  = hjct_pkg::MAX_ENTRIES_DEF,
    parameter int PAYLOAD_BITS = hjct_pkg::PAYLOAD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // kind
    input  logic [127:0] s_tdata,   // hash_value[63:0], payload_in[127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [1:0]   m_tuser,   // status
    output logic [79:0]  m_tdata    // has_entry[0], payload_out[64:1], bucket_count[75:65]
);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = IW + 1;
    localparam int HW = hjct_pkg::HASH_BITS;
    localparam int NW = hjct_pkg::COUNT_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_PRB_RD, S_PRB_WAIT, S_NXT_RD, S_NXT_WAIT, S_ENT_RD, S_ENT_WAIT,
        S_CLR, S_BLD_RD, S_BLD_HD, S_BLD_WR, S_OUT
    } state_t;

    // memories: entry hash, payload, next link (valid + index), bucket heads
    logic [HW-1:0]           hash_mem [MAX_ENTRIES];
    logic [PAYLOAD_BITS-1:0] pay_mem  [MAX_ENTRIES];
    logic [IW:0]             next_mem [MAX_ENTRIES];
    logic [IW:0]             head_mem [2**IW];

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [IW-1:0]       mask_reg;
    logic                built_reg;
    logic                cur_ok_reg;
    logic [IW-1:0]       cur_reg;
    logic [CW-1:0]       idx_reg;
    logic [HW-1:0]       hash_reg;
    logic [1:0]          st_reg;
    logic                out_has_reg;
    logic [PAYLOAD_BITS-1:0] out_pay_reg;

    // memory ports
    logic [IW-1:0]       ent_raddr, head_raddr;
    logic [HW-1:0]       hash_rd;
    logic [PAYLOAD_BITS-1:0] pay_rd;
    logic [IW:0]         next_rd, head_rd;
    logic                ent_we, head_we, next_we;
    logic [IW-1:0]       ent_waddr, head_waddr, next_waddr;
    logic [IW:0]         head_wdata, next_wdata;

    logic [HW-1:0]           in_hash;
    logic [PAYLOAD_BITS-1:0] in_pay;
    logic [IW-1:0]           bucket_pos;
    logic [IW-1:0]           size_m1;
    logic                    s_fire;

    assign in_hash = s_tdata[HW-1:0];
    assign in_pay  = s_tdata[64 +: PAYLOAD_BITS];
    assign s_tready = (state_reg == S_IDLE) && !m_tvalid;
    assign s_fire  = s_tvalid && s_tready;
    assign bucket_pos = hash_reg[IW-1:0] & mask_reg;

    // smallest power of two at or above count, minus one
    always_comb
    begin
        size_m1 = '0;
        if (count_reg > CW'(1))
        begin
            size_m1 = IW'((count_reg - CW'(1)));
            for (int k = 1; k < IW; k = k * 2)
                size_m1 = size_m1 | (size_m1 >> k);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            hash_mem[ent_waddr] <= in_hash;
            pay_mem[ent_waddr]  <= in_pay;
        end
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        hash_rd <= hash_mem[ent_raddr];
        pay_rd  <= pay_mem[ent_raddr];
        next_rd <= next_mem[ent_raddr];
        head_rd <= head_mem[head_raddr];
    end

    // memory control
    always_comb
    begin
        ent_we     = s_fire && (hjct_pkg::kind_t'(s_tuser) == hjct_pkg::KIND_INSERT)
                     && !built_reg && (count_reg < CW'(MAX_ENTRIES));
        ent_waddr  = count_reg[IW-1:0];
        ent_raddr  = idx_reg[IW-1:0];
        if (state_reg == S_ENT_RD || state_reg == S_NXT_RD)
            ent_raddr = cur_reg;
        // during build, look up the head straight from the entry hash just read
        head_raddr = bucket_pos;
        if (state_reg == S_BLD_HD)
            head_raddr = hash_rd[IW-1:0] & mask_reg;
        head_we    = 1'b0;
        head_waddr = idx_reg[IW-1:0];
        head_wdata = '0;
        next_we    = 1'b0;
        next_waddr = idx_reg[IW-1:0];
        next_wdata = head_rd;
        unique case (state_reg)
            S_CLR:
                head_we = 1'b1;
            S_BLD_WR:
            begin
                head_we    = 1'b1;
                head_waddr = bucket_pos;
                head_wdata = {1'b1, idx_reg[IW-1:0]};
                next_we    = 1'b1;
            end
            default:
                head_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            mask_reg   <= '0;
            built_reg  <= 1'b0;
            cur_ok_reg <= 1'b0;
            cur_reg    <= '0;
            idx_reg    <= '0;
            hash_reg   <= '0;
            m_tvalid   <= 1'b0;
            st_reg     <= hjct_pkg::ST_OK;
            out_has_reg <= 1'b0;
            out_pay_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (m_tvalid && m_tready)
                        m_tvalid <= 1'b0;
                    if (s_fire)
                    begin
                        hash_reg    <= in_hash;
                        out_has_reg <= 1'b0;
                        out_pay_reg <= '0;
                        unique case (hjct_pkg::kind_t'(s_tuser))
                            hjct_pkg::KIND_INSERT:
                            begin
                                m_tvalid <= 1'b1;
                                if (built_reg)
                                    st_reg <= hjct_pkg::ST_PHASE;
                                else if (count_reg >= CW'(MAX_ENTRIES))
                                    st_reg <= hjct_pkg::ST_FULL;
                                else
                                begin
                                    st_reg    <= hjct_pkg::ST_OK;
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            hjct_pkg::KIND_BUILD:
                            begin
                                if (built_reg)
                                begin
                                    st_reg   <= hjct_pkg::ST_PHASE;
                                    m_tvalid <= 1'b1;
                                end
                                else
                                begin
                                    st_reg     <= hjct_pkg::ST_OK;
                                    mask_reg   <= size_m1;
                                    cur_ok_reg <= 1'b0;
                                    idx_reg    <= '0;
                                    state_reg  <= S_CLR;
                                end
                            end
                            hjct_pkg::KIND_PROBE:
                            begin
                                if (!built_reg)
                                begin
                                    st_reg   <= hjct_pkg::ST_PHASE;
                                    m_tvalid <= 1'b1;
                                end
                                else
                                begin
                                    st_reg    <= hjct_pkg::ST_OK;
                                    state_reg <= S_PRB_RD;
                                end
                            end
                            hjct_pkg::KIND_NEXT:
                            begin
                                if (!built_reg)
                                begin
                                    st_reg   <= hjct_pkg::ST_PHASE;
                                    m_tvalid <= 1'b1;
                                end
                                else if (cur_ok_reg)
                                begin
                                    st_reg    <= hjct_pkg::ST_OK;
                                    state_reg <= S_NXT_RD;
                                end
                                else
                                begin
                                    st_reg   <= hjct_pkg::ST_OK;
                                    m_tvalid <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                // head read is issued from hash_reg this cycle
                S_PRB_RD:
                    state_reg <= S_PRB_WAIT;
                // point the cursor at the chain head
                S_PRB_WAIT:
                begin
                    cur_reg    <= head_rd[IW-1:0];
                    cur_ok_reg <= head_rd[IW];
                    state_reg  <= S_ENT_RD;
                end
                // link read is issued from the cursor this cycle
                S_NXT_RD:
                    state_reg <= S_NXT_WAIT;
                // advance the cursor along the chain
                S_NXT_WAIT:
                begin
                    cur_reg    <= next_rd[IW-1:0];
                    cur_ok_reg <= next_rd[IW];
                    state_reg  <= S_ENT_RD;
                end
                S_ENT_RD:
                    state_reg <= S_ENT_WAIT;
                // capture the payload under the cursor, zero when none
                S_ENT_WAIT:
                begin
                    out_has_reg <= cur_ok_reg;
                    out_pay_reg <= cur_ok_reg ? pay_rd : '0;
                    state_reg   <= S_OUT;
                end
                // sweep heads clear up to the new mask
                S_CLR:
                begin
                    if (idx_reg[IW-1:0] == mask_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= (count_reg == '0) ? S_OUT : S_BLD_RD;
                    end
                    else
                        idx_reg <= idx_reg + CW'(1);
                end
                S_BLD_RD:
                    state_reg <= S_BLD_HD;
                S_BLD_HD:
                begin
                    hash_reg  <= hash_rd;
                    state_reg <= S_BLD_WR;
                end
                S_BLD_WR:
                begin
                    if (idx_reg + CW'(1) == count_reg)
                        state_reg <= S_OUT;
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_BLD_RD;
                    end
                end
                S_OUT:
                begin
                    built_reg <= 1'b1;
                    m_tvalid  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tuser = st_reg;
    assign m_tdata = {4'd0, NW'({1'b0, mask_reg}) + NW'(1),
                      64'(out_pay_reg), out_has_reg};

endmodule
